// File: design/tlpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page table map/translate block.
// ----------------------------------------------------------------------------
package tlpt_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int IDX_W           = 10;
    localparam int DIR_ENTRIES     = 1 << IDX_W;
    localparam int TBL_ENTRIES     = 1 << IDX_W;
    localparam int DIR_SHIFT       = 22;
    localparam int TBL_SHIFT       = 12;
    localparam int ADDR_W          = 32;
    localparam int FRAME_W         = ADDR_W - TBL_SHIFT;
    localparam int IN_TDATA_W      = 72;
    localparam int OUT_TDATA_W     = 40;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_DIR = 2'd1,
        ST_NO_PTE = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        REQ_MAP       = 1'b0,
        REQ_TRANSLATE = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_PTE,
        S_WAIT
    } state_t;

endpackage
`default_nettype wire

// File: design/two_level_page_table_map_translate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_page_table_map_translate
// Map and translate requests against a 1024-entry page directory and a pool
// of TABLE_SLOTS page tables held in two synchronous RAMs.
// ----------------------------------------------------------------------------
// results: a map, or a translate with no directory entry, takes its result
//   from the directory read; a translate that reaches a page table takes it
//   from the dependent table read that follows the directory read
// throughput: one request at a time; a new one is taken only back in S_IDLE
// reset: a clearing pass over every page table address wipes both RAMs; no input
//   transfer is taken until it ends
// ----------------------------------------------------------------------------
module two_level_page_table_map_translate #(
    parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // req_type [0], vaddr [32:1], paddr [64:33], zero fill
    input  wire logic [tlpt_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // frame_base [31:0], status [33:32], zero fill
    output logic      [tlpt_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    import tlpt_pkg::*;

    localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int PTE_DEPTH = TABLE_SLOTS * TBL_ENTRIES;
    localparam int PTE_AW    = $clog2(PTE_DEPTH);
    localparam int DIR_AW    = IDX_W;
    localparam int DIR_W     = 1 + SLOT_W;
    localparam int PTE_W     = 1 + FRAME_W;

    state_t                state_reg, state_next;
    logic [PTE_AW-1:0]     clr_reg;
    logic [CNT_W-1:0]      slots_used_reg;
    logic                  req_reg;
    logic [IDX_W-1:0]      di_reg;
    logic [IDX_W-1:0]      ti_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic [FRAME_W-1:0]    pend_frame_reg;
    status_t               pend_status_reg;
    logic                  m_tvalid_reg;
    logic [ADDR_W-1:0]     m_frame_reg;
    status_t               m_status_reg;

    logic                  in_xfer;
    logic                  out_free;
    logic                  clr_done;
    logic                  dir_hit;
    logic [SLOT_W-1:0]     dir_slot;
    logic                  pool_full;
    logic [SLOT_W-1:0]     slot_sel;
    logic [SLOT_W+IDX_W-1:0] pte_cat;
    logic [PTE_AW-1:0]     pte_addr;

    logic                  dir_we;
    logic [DIR_AW-1:0]     dir_waddr;
    logic [DIR_W-1:0]      dir_wdata;
    logic [DIR_AW-1:0]     dir_raddr;
    logic [DIR_W-1:0]      dir_rdata;
    logic                  pte_we;
    logic [PTE_AW-1:0]     pte_waddr;
    logic [PTE_W-1:0]      pte_wdata;
    logic [PTE_W-1:0]      pte_rdata;

    logic                  res_done;
    logic [FRAME_W-1:0]    res_frame;
    status_t               res_status;
    logic                  slot_claim;
    logic                  out_load;
    logic                  pend_load;

    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign clr_done  = (clr_reg == PTE_AW'(PTE_DEPTH - 1));
    assign dir_hit   = dir_rdata[DIR_W-1];
    assign dir_slot  = dir_rdata[SLOT_W-1:0];
    assign pool_full = (slots_used_reg >= CNT_W'(TABLE_SLOTS));
    assign slot_sel  = dir_hit ? dir_slot : slots_used_reg[SLOT_W-1:0];
    assign pte_cat   = {slot_sel, ti_reg};
    assign pte_addr  = pte_cat[PTE_AW-1:0];
    assign dir_raddr = s_tdata[1+DIR_SHIFT +: IDX_W];

    tlpt_ram #(
        .WIDTH (DIR_W),
        .DEPTH (DIR_ENTRIES)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    tlpt_ram #(
        .WIDTH (PTE_W),
        .DEPTH (PTE_DEPTH)
    ) u_pte_ram (
        .clk   (clk),
        .we    (pte_we),
        .waddr (pte_waddr),
        .wdata (pte_wdata),
        .raddr (pte_addr),
        .rdata (pte_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                if (req_reg == REQ_TRANSLATE && dir_hit)
                begin
                    state_next = S_PTE;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_PTE:
            begin
                state_next = out_free ? S_IDLE : S_WAIT;
            end
            S_WAIT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // ram controls and result
    always_comb
    begin
        dir_we     = 1'b0;
        dir_waddr  = di_reg;
        dir_wdata  = {1'b1, slots_used_reg[SLOT_W-1:0]};
        pte_we     = 1'b0;
        pte_waddr  = pte_addr;
        pte_wdata  = {1'b1, frame_reg};
        res_done   = 1'b0;
        res_frame  = '0;
        res_status = ST_OK;
        slot_claim = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                dir_we    = 1'b1;
                dir_waddr = clr_reg[DIR_AW-1:0];
                dir_wdata = '0;
                pte_we    = 1'b1;
                pte_waddr = clr_reg;
                pte_wdata = '0;
            end
            S_DIR:
            begin
                if (req_reg == REQ_MAP)
                begin
                    res_done = 1'b1;
                    if (!dir_hit && pool_full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        pte_we = 1'b1;
                        if (!dir_hit)
                        begin
                            dir_we     = 1'b1;
                            slot_claim = 1'b1;
                        end
                    end
                end
                else if (!dir_hit)
                begin
                    res_done   = 1'b1;
                    res_status = ST_NO_DIR;
                end
            end
            S_PTE:
            begin
                res_done = 1'b1;
                if (pte_rdata[PTE_W-1])
                begin
                    res_frame = pte_rdata[FRAME_W-1:0];
                end
                else
                begin
                    res_status = ST_NO_PTE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_load  = (res_done || state_reg == S_WAIT) && out_free;
    assign pend_load = res_done && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            slots_used_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR && !clr_done)
            begin
                clr_reg <= clr_reg + PTE_AW'(1);
            end
            if (slot_claim)
            begin
                slots_used_reg <= slots_used_reg + CNT_W'(1);
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg   <= s_tdata[0];
            di_reg    <= s_tdata[1+DIR_SHIFT +: IDX_W];
            ti_reg    <= s_tdata[1+TBL_SHIFT +: IDX_W];
            frame_reg <= s_tdata[1+ADDR_W+TBL_SHIFT +: FRAME_W];
        end
        if (pend_load)
        begin
            pend_frame_reg  <= res_frame;
            pend_status_reg <= res_status;
        end
        if (out_load)
        begin
            if (state_reg == S_WAIT)
            begin
                m_frame_reg  <= {pend_frame_reg, TBL_SHIFT'(0)};
                m_status_reg <= pend_status_reg;
            end
            else
            begin
                m_frame_reg  <= {res_frame, TBL_SHIFT'(0)};
                m_status_reg <= res_status;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - ADDR_W - 2){1'b0}}, m_status_reg, m_frame_reg};

endmodule
`default_nettype wire

// File: design/tlpt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
